// ----- hdl/mrcc_pkg.sv -----
// Shared types, constants and the CRC-32 column table of the ROM checker.
package mrcc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STAGE_W  = 3;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // Stage codes.
    localparam logic [STAGE_W-1:0] ST_INIT    = 3'd0;
    localparam logic [STAGE_W-1:0] ST_RESTART = 3'd1;
    localparam logic [STAGE_W-1:0] ST_SAFETY  = 3'd2;
    localparam logic [STAGE_W-1:0] ST_CONFIG  = 3'd3;
    localparam logic [STAGE_W-1:0] ST_APP     = 3'd4;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SAFETY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CONFIG = 2'd2;
    localparam logic [ERR_W-1:0] ERR_APP    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_END      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_CRC      = 3'd6;

    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [WORD_W-1:0] CNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] ADDR_STEP = 32'd4;

    localparam logic [WORD_W-1:0] RST_SAFETY_START = 32'h0800_E800;
    localparam logic [WORD_W-1:0] RST_SAFETY_END   = 32'h0800_FFFC;
    localparam logic [WORD_W-1:0] RST_CONFIG_START = 32'h0800_E000;
    localparam logic [WORD_W-1:0] RST_CONFIG_END   = 32'h0800_E7FC;

    // Input queue between the accepting side and the step engine.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [WORD_W-1:0][WORD_W-1:0] crc_cols_t;

    typedef struct packed {
        word_t safety_start;
        word_t safety_end;
        word_t config_start;
        word_t config_end;
        word_t app_start;
        word_t app_end;
        word_t app_crc;
    } cfg_t;

    typedef struct packed {
        word_t                fetch_addr;
        logic [STAGE_W-1:0]   check_stage;
        word_t                fault_count;
        word_t                pass_count;
        logic [ERR_W-1:0]     error_code;
        word_t                running_crc;
    } result_t;

    // Folding a whole word is linear over GF(2): column i is the result of
    // folding a word that has only bit i set into a zero register.
    function automatic crc_cols_t crc_columns();
        crc_cols_t cols;
        word_t     r;
        for (int i = 0; i < WORD_W; i++) begin
            r = word_t'(1) << i;
            for (int j = 0; j < WORD_W; j++) begin
                if (r[WORD_W-1]) begin
                    r = (r << 1) ^ CRC_POLY;
                end else begin
                    r = r << 1;
                end
            end
            cols[i] = r;
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = crc_columns();

    function automatic word_t crc_fold(input word_t crc, input word_t data);
        word_t x;
        word_t r;
        x = crc ^ data;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (x[i]) begin
                r = r ^ CRC_COLS[i];
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/multi_region_rom_crc_checker.sv -----
// Top level of the background ROM CRC checker with its register file.
//
// Background ROM checker. Every input beat carries the 32-bit word read at the
// fetch_addr of the previous result beat, and every input beat yields exactly
// one result beat. The block walks the safety, configuration and application
// regions in turn, folding each word into a CRC-32 (polynomial 0x04C11DB7,
// MSB first, initial value 0xFFFFFFFF, no final XOR) while the address is
// below the region end. At a region end the CRC is compared with the word
// stored at the end address (safety and configuration) or with the expected
// CRC register (application). A mismatch counts a fault, records an error
// code and returns to the init stage, whose next step clears the counters.
// Throughput is one beat per clock cycle while m_axis_tready does not stall:
// the state registers of the step engine are also the result register, so the
// whole word-wide CRC fold and the end-address compare sit between two registers.
// A two-entry queue sits in front of the step engine, so the input side keeps
// accepting beats while a result waits on m_axis_tready, until the queue is full;
// an accepted beat is held in a queue entry, then folded into the engine registers.
// Configuration registers are written through the cfg_* channel, which is
// always ready; writes should only be made while no beat is in flight.
module multi_region_rom_crc_checker
    import mrcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] rom_word

    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] fetch_addr, [34:32] check_stage, [66:35] fault_count,
    // [98:67] pass_count, [100:99] error_code, [132:101] running_crc,
    // [135:133] zero
    output logic [135:0]         m_axis_tdata,

    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    result_t result;
    word_t   queue_data;
    logic    queue_full;
    logic    queue_not_empty;
    logic    step;
    logic    out_valid_reg, out_valid_next;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SAFETY_START: cfg_next.safety_start = cfg_data;
                CFG_SAFETY_END:   cfg_next.safety_end   = cfg_data;
                CFG_CONFIG_START: cfg_next.config_start = cfg_data;
                CFG_CONFIG_END:   cfg_next.config_end   = cfg_data;
                CFG_APP_START:    cfg_next.app_start    = cfg_data;
                CFG_APP_END:      cfg_next.app_end      = cfg_data;
                CFG_APP_CRC:      cfg_next.app_crc      = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.safety_start <= RST_SAFETY_START;
            cfg_reg.safety_end   <= RST_SAFETY_END;
            cfg_reg.config_start <= RST_CONFIG_START;
            cfg_reg.config_end   <= RST_CONFIG_END;
            cfg_reg.app_start    <= '0;
            cfg_reg.app_end      <= '0;
            cfg_reg.app_crc      <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept beats into the queue whenever it has room.
    assign s_axis_tready = !queue_full;

    mrcc_beat_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_axis_tvalid && s_axis_tready),
        .push_data (s_axis_tdata),
        .full      (queue_full),
        .pop       (step),
        .not_empty (queue_not_empty),
        .pop_data  (queue_data)
    );

    // Back: a step runs when a word is queued and the result register is
    // free or being emptied in this same cycle.
    assign step = queue_not_empty && (!out_valid_reg || m_axis_tready);

    mrcc_step_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .rom_word (queue_data),
        .cfg      (cfg_reg),
        .result   (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, result.running_crc, result.error_code,
                            result.pass_count, result.fault_count,
                            result.check_stage, result.fetch_addr};

endmodule

// ----- hdl/mrcc_beat_queue.sv -----
// Two-entry queue that takes input beats and hands them to the step engine.
module mrcc_beat_queue
    import mrcc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  word_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output word_t pop_data
);

    word_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/mrcc_step_engine.sv -----
// Region walker: takes one ROM word per step and holds the result state.
module mrcc_step_engine
    import mrcc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  word_t   rom_word,
    input  cfg_t    cfg,
    output result_t result
);

    logic [STAGE_W-1:0] stage_reg, stage_next;
    word_t              crc_reg, crc_next;
    word_t              addr_reg, addr_next;
    word_t              fault_reg, fault_next;
    word_t              pass_reg, pass_next;
    logic [ERR_W-1:0]   err_reg, err_next;

    word_t region_end;
    logic  in_region;
    word_t folded;
    word_t fault_inc;

    always_comb begin
        unique case (stage_reg)
            ST_SAFETY: region_end = cfg.safety_end;
            ST_CONFIG: region_end = cfg.config_end;
            default:   region_end = cfg.app_end;
        endcase
    end

    assign in_region = (addr_reg < region_end);
    assign folded    = crc_fold(crc_reg, rom_word);
    assign fault_inc = (fault_reg != CNT_MAX) ? fault_reg + 1'b1 : fault_reg;

    always_comb begin
        stage_next = stage_reg;
        crc_next   = crc_reg;
        addr_next  = addr_reg;
        fault_next = fault_reg;
        pass_next  = pass_reg;
        err_next   = err_reg;
        unique case (stage_reg)
            ST_INIT: begin
                fault_next = '0;
                pass_next  = '0;
                err_next   = ERR_OK;
                stage_next = ST_RESTART;
            end
            ST_RESTART: begin
                addr_next  = cfg.safety_start;
                crc_next   = CRC_INIT;
                stage_next = ST_SAFETY;
            end
            ST_SAFETY: begin
                if (in_region) begin
                    crc_next  = folded;
                    addr_next = addr_reg + ADDR_STEP;
                end else if (rom_word == crc_reg) begin
                    stage_next = ST_CONFIG;
                    crc_next   = CRC_INIT;
                    addr_next  = cfg.config_start;
                end else begin
                    fault_next = fault_inc;
                    err_next   = ERR_SAFETY;
                    stage_next = ST_INIT;
                end
            end
            ST_CONFIG: begin
                if (in_region) begin
                    crc_next  = folded;
                    addr_next = addr_reg + ADDR_STEP;
                end else if (rom_word == crc_reg) begin
                    stage_next = ST_APP;
                    crc_next   = CRC_INIT;
                    addr_next  = cfg.app_start;
                end else begin
                    fault_next = fault_inc;
                    err_next   = ERR_CONFIG;
                    stage_next = ST_INIT;
                end
            end
            ST_APP: begin
                if (in_region) begin
                    crc_next  = folded;
                    addr_next = addr_reg + ADDR_STEP;
                end else if (cfg.app_crc == crc_reg) begin
                    stage_next = ST_RESTART;
                    pass_next  = (pass_reg != CNT_MAX) ? pass_reg + 1'b1 : pass_reg;
                end else begin
                    fault_next = fault_inc;
                    err_next   = ERR_APP;
                    stage_next = ST_INIT;
                end
            end
            default: begin
                stage_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_INIT;
            crc_reg   <= CRC_INIT;
            addr_reg  <= '0;
            fault_reg <= '0;
            pass_reg  <= '0;
            err_reg   <= ERR_OK;
        end else if (step) begin
            stage_reg <= stage_next;
            crc_reg   <= crc_next;
            addr_reg  <= addr_next;
            fault_reg <= fault_next;
            pass_reg  <= pass_next;
            err_reg   <= err_next;
        end
    end

    assign result.fetch_addr  = addr_reg;
    assign result.check_stage = stage_reg;
    assign result.fault_count = fault_reg;
    assign result.pass_count  = pass_reg;
    assign result.error_code  = err_reg;
    assign result.running_crc = crc_reg;

endmodule
